### sv/mssc_pkg.sv
package mssc_pkg;

    typedef logic [1:0] op_t;
    typedef logic [3:0] digit_t;
    typedef logic [6:0] seg_t;
    typedef logic [8:0] period_t;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_PRESS = 2'd1;
    localparam op_t OP_ADC   = 2'd2;

    localparam int DEFAULT_NUM_DIGITS = 4;

    localparam int SAMPLE_W     = 10;
    localparam int IN_TDATA_W   = 16;
    localparam int OP_W         = 2;
    localparam int SEG_W        = 7;
    localparam int PERIOD_W     = 9;

    localparam logic [SAMPLE_W-1:0] ADC_SPLIT = 10'd500;
    localparam period_t             HIGH_BASE = 9'd51;
    localparam digit_t              DIGIT_MAX = 4'd9;

    localparam seg_t SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Digits above nine never occur, but they would show as a blank digit.
    function automatic seg_t seg_of(input digit_t d);
        seg_t r;
        r = 7'd0;
        if (d <= DIGIT_MAX)
        begin
            r = SEG_TABLE[d];
        end
        return r;
    endfunction

    // Both divisions use a scaled reciprocal that is exact over the
    // whole 10-bit input range: s/10 as (s*205)>>11, u/5 as (u*3277)>>14.
    function automatic period_t period_of(input logic [SAMPLE_W-1:0] s);
        logic [17:0] lo_prod;
        logic [9:0]  t;
        logic [11:0] t4;
        logic [23:0] hi_prod;
        period_t     r;
        lo_prod = 18'(s) * 18'd205;
        t       = s - ADC_SPLIT;
        t4      = {t, 2'b00};
        hi_prod = 24'(t4) * 24'd3277;
        if (s < ADC_SPLIT)
        begin
            r = 9'd1 + 9'(lo_prod[17:11]);
        end
        else
        begin
            r = HIGH_BASE + 9'(hi_prod[23:14]);
        end
        return r;
    endfunction

endpackage

### sv/multiplexed_seven_segment_counter.sv
// Multiplexed seven-segment display driver with a decimal counter.
//
// Input channel (s_axis): tuser carries the operation (scan tick, button press
// or converter sample) and tdata the 10-bit converter sample. Output channel
// (m_axis): one transaction per input transaction, carrying the segment
// pattern, the one-hot digit enable and the refresh period packed in tdata.
//
// A tick steps the scan position down through the digits, wrapping to the
// most significant one, and latches that digit's pattern and enable. A press
// adds one to the decimal counter, wrapping to zero from all nines. A sample
// gives the timer refresh period; other operations report a period of zero.
//
// An accepted input transaction's result appears on m_axis in the next cycle.
// One transaction is taken every cycle while the receiver is ready: the single
// output register is refilled in the same cycle that the receiver takes its
// contents. When the receiver stalls with a result pending, s_axis_tready
// drops until it is taken. Reset clears the counter and the latches, sets the
// scan position to the most significant digit and empties the output register;
// no result is presented until the first input transaction.
module multiplexed_seven_segment_counter #(
    parameter int NUM_DIGITS = mssc_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [9:0] adc_sample, [15:10] zero
    input  logic [mssc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [mssc_pkg::OP_W-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [6:0] segments, [6+NUM_DIGITS:7] digit_enable,
    // [15+NUM_DIGITS:7+NUM_DIGITS] refresh_period, rest zero
    output logic [((mssc_pkg::SEG_W + NUM_DIGITS + mssc_pkg::PERIOD_W + 7) / 8) * 8 - 1:0]
                                         m_axis_tdata
);
    import mssc_pkg::*;

    localparam int OUT_W       = SEG_W + NUM_DIGITS + PERIOD_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int PW          = $clog2(NUM_DIGITS + 1);
    localparam int IDXW        = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [PW-1:0] POS_MAX = PW'(NUM_DIGITS);
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    logic [PW-1:0]         pos_reg, pos_next;
    digit_t                digits_reg  [NUM_DIGITS];
    digit_t                digits_next [NUM_DIGITS];
    digit_t                digits_inc  [NUM_DIGITS];
    seg_t                  seg_reg, seg_next;
    logic [NUM_DIGITS-1:0] en_reg, en_next;
    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                  in_accept;
    op_t                   op;
    logic [SAMPLE_W-1:0]   sample;
    logic [PW-1:0]         pos_tick;
    logic [PW-1:0]         idx_full;
    logic [IDXW-1:0]       idx;
    period_t               period;

    assign op        = s_axis_tuser;
    assign sample    = s_axis_tdata[SAMPLE_W-1:0];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign pos_tick = (pos_reg <= POS_ONE || pos_reg > POS_MAX) ? POS_MAX : pos_reg - POS_ONE;
    assign idx_full = POS_MAX - pos_tick;
    assign idx      = idx_full[IDXW-1:0];

    // Decimal increment: a digit steps only when every less significant digit
    // is nine. Index 0 is the most significant digit.
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            if (carry)
            begin
                digits_inc[i] = (digits_reg[i] >= DIGIT_MAX) ? 4'd0 : digits_reg[i] + 4'd1;
            end
            else
            begin
                digits_inc[i] = digits_reg[i];
            end
            carry = carry && (digits_reg[i] >= DIGIT_MAX);
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        digits_next = digits_reg;
        seg_next    = seg_reg;
        en_next     = en_reg;
        period      = '0;
        case (op)
            OP_TICK:
            begin
                pos_next = pos_tick;
                seg_next = seg_of(digits_reg[idx]);
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    en_next[i] = (pos_tick == PW'(i + 1));
                end
            end
            OP_PRESS:
            begin
                digits_next = digits_inc;
            end
            OP_ADC:
            begin
                period = period_of(sample);
            end
            default:
            begin
                period = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_MAX;
            seg_reg       <= '0;
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digits_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_accept)
            begin
                pos_reg       <= pos_next;
                seg_reg       <= seg_next;
                en_reg        <= en_next;
                digits_reg    <= digits_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= OUT_TDATA_W'({period, en_next, seg_next});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### sv/mssc_checker.sv
module mssc_checker #(
    parameter int NUM_DIGITS = mssc_pkg::DEFAULT_NUM_DIGITS
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [mssc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input logic [mssc_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [((mssc_pkg::SEG_W + NUM_DIGITS + mssc_pkg::PERIOD_W + 7) / 8) * 8 - 1:0]
                                        m_axis_tdata
);
    import mssc_pkg::*;

    localparam int EN_LO  = SEG_W;
    localparam int PER_LO = SEG_W + NUM_DIGITS;

    logic                  in_accept;
    logic [NUM_DIGITS-1:0] enable_field;
    period_t               period_field;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign enable_field = m_axis_tdata[EN_LO +: NUM_DIGITS];
    assign period_field = m_axis_tdata[PER_LO +: PERIOD_W];

    // Every accepted transaction yields a result in the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("no result after an accepted transaction");

    // A pending result must hold until the receiver takes it.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result changed or dropped");

    // Only a converter sample may report a non-zero refresh period.
    a_period_only_adc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser != OP_ADC |=> period_field == '0)
        else $error("refresh period reported for a non-sample transaction");

    // At most one digit is ever enabled.
    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(enable_field))
        else $error("more than one digit enabled");

endmodule

bind multiplexed_seven_segment_counter mssc_checker #(.NUM_DIGITS(NUM_DIGITS)) u_mssc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
